@@ sv/arlm_pkg.sv @@
// Shared types, codes and constants for the AT response line matcher.
// Depends on nothing; used by every module of the block.
package arlm_pkg;

   // Defaults for the top-level parameters
   localparam int BUF_MAX_DEF  = 256;
   localparam int LINE_MAX_DEF = 16;

   // Fixed payload widths
   localparam int FUNC_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int SIZE_W  = 9;
   localparam int WAIT_W  = 15;
   localparam int INDEX_W = 8;
   localparam int STAT_W  = 2;

   // Result queue depth and the fill level up to which a request may enter
   localparam int RSP_DEPTH   = 8;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);
   localparam int RSP_ACCEPT_LIMIT = RSP_DEPTH - 4;

   // Request kinds
   localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BYTE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

   // Completion status codes
   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_ERROR   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FAIL    = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_TIMEOUT = 2'd3;

   // Line control characters
   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

   // Status words: index into word_char, and their lengths
   localparam logic [1:0] WORD_OK    = 2'd0;
   localparam logic [1:0] WORD_ERROR = 2'd1;
   localparam logic [1:0] WORD_FAIL  = 2'd2;
   localparam int LEN_OK    = 2;
   localparam int LEN_ERROR = 5;
   localparam int LEN_FAIL  = 4;

   typedef struct packed {
      logic                  write_en;
      logic [INDEX_W-1:0]    write_index;
      logic [BYTE_W-1:0]     write_byte;
      logic                  done_res;
      logic [STAT_W-1:0]     status;
      logic                  last;
   } rsp_item_type;

   // Up to two results per request, first in order in item_a
   typedef struct packed {
      logic [1:0]    count;
      rsp_item_type  item_a;
      rsp_item_type  item_b;
   } rsp_push_type;

   // Character at position pos of a status word
   function automatic logic [BYTE_W-1:0] word_char(input logic [1:0] word,
                                                   input logic [2:0] pos);
      logic [BYTE_W-1:0] ch;
      ch = 8'h00;
      case (word)
         WORD_OK: begin
            case (pos)
               3'd0:    ch = 8'h4F; // O
               3'd1:    ch = 8'h4B; // K
               default: ch = 8'h00;
            endcase
         end
         WORD_ERROR: begin
            case (pos)
               3'd0:    ch = 8'h45; // E
               3'd1:    ch = 8'h52; // R
               3'd2:    ch = 8'h52; // R
               3'd3:    ch = 8'h4F; // O
               3'd4:    ch = 8'h52; // R
               default: ch = 8'h00;
            endcase
         end
         WORD_FAIL: begin
            case (pos)
               3'd0:    ch = 8'h46; // F
               3'd1:    ch = 8'h41; // A
               3'd2:    ch = 8'h49; // I
               3'd3:    ch = 8'h4C; // L
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

@@ sv/arlm_engine.sv @@
// Command state and per-request result logic of the AT response line matcher.
// Depends on arlm_pkg; fed from the request register in the top level.
module arlm_engine #(
   parameter int BUF_MAX  = arlm_pkg::BUF_MAX_DEF,
   parameter int LINE_MAX = arlm_pkg::LINE_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  logic [arlm_pkg::FUNC_W-1:0]   item_func,
   input  logic [arlm_pkg::BYTE_W-1:0]   item_rx_byte,
   input  logic [arlm_pkg::SIZE_W-1:0]   item_buf_size,
   input  logic [arlm_pkg::WAIT_W-1:0]   item_wait_limit,
   output arlm_pkg::rsp_push_type        push
);
   import arlm_pkg::*;

   localparam int LEN_W = $clog2(LINE_MAX + 1);
   localparam int SIZE_LIMIT = (1 << SIZE_W) - 1;
   localparam logic [SIZE_W-1:0] SIZE_CAP =
      SIZE_W'((BUF_MAX > SIZE_LIMIT) ? SIZE_LIMIT : BUF_MAX);
   localparam logic [LEN_W-1:0] LINE_CAP  = LEN_W'(LINE_MAX);
   localparam logic [LEN_W-1:0] L_OK      = LEN_W'(LEN_OK);
   localparam logic [LEN_W-1:0] L_ERROR   = LEN_W'(LEN_ERROR);
   localparam logic [LEN_W-1:0] L_FAIL    = LEN_W'(LEN_FAIL);

   logic                active_ff, active_in;
   logic [SIZE_W-1:0]   space_ff, space_in;
   logic [SIZE_W-1:0]   wptr_ff, wptr_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [2:0]          flags_ff, flags_in;
   logic [WAIT_W-1:0]   reload_ff, reload_in;
   logic [WAIT_W-1:0]   wcount_ff, wcount_in;

   logic [SIZE_W-1:0]   size_eff;
   logic [WAIT_W-1:0]   wait_eff;
   logic                store, eol, hit;
   logic [STAT_W-1:0]   hit_code;
   logic [SIZE_W-1:0]   space_next, wptr_next;
   rsp_item_type        store_item, done_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         space_ff  <= '0;
         wptr_ff   <= '0;
         len_ff    <= '0;
         flags_ff  <= 3'b111;
         reload_ff <= WAIT_W'(1);
         wcount_ff <= WAIT_W'(1);
      end else begin
         active_ff <= active_in;
         space_ff  <= space_in;
         wptr_ff   <= wptr_in;
         len_ff    <= len_in;
         flags_ff  <= flags_in;
         reload_ff <= reload_in;
         wcount_ff <= wcount_in;
      end
   end

   always_comb begin
      active_in = active_ff;
      space_in  = space_ff;
      wptr_in   = wptr_ff;
      len_in    = len_ff;
      flags_in  = flags_ff;
      reload_in = reload_ff;
      wcount_in = wcount_ff;
      push      = '0;

      if (item_buf_size == '0) begin
         size_eff = SIZE_W'(1);
      end else if (item_buf_size > SIZE_CAP) begin
         size_eff = SIZE_CAP;
      end else begin
         size_eff = item_buf_size;
      end
      wait_eff = (item_wait_limit == '0) ? WAIT_W'(1) : item_wait_limit;

      store = (space_ff != '0) && (item_rx_byte != CH_CR);
      eol   = (item_rx_byte == CH_CR) || (item_rx_byte == CH_LF);
      space_next = store ? space_ff - SIZE_W'(1) : space_ff;
      wptr_next  = store ? wptr_ff + SIZE_W'(1) : wptr_ff;

      // First word still matching at its full length wins
      hit      = 1'b1;
      hit_code = STATUS_OK;
      if (flags_ff[0] && len_ff == L_OK) begin
         hit_code = STATUS_OK;
      end else if (flags_ff[1] && len_ff == L_ERROR) begin
         hit_code = STATUS_ERROR;
      end else if (flags_ff[2] && len_ff == L_FAIL) begin
         hit_code = STATUS_FAIL;
      end else begin
         hit = 1'b0;
      end

      store_item             = '0;
      store_item.write_en    = 1'b1;
      store_item.write_index = wptr_ff[INDEX_W-1:0];
      store_item.write_byte  = item_rx_byte;
      store_item.last        = !(eol && hit);

      done_item          = '0;
      done_item.write_en = (space_next != '0);
      if (space_next != '0) begin
         done_item.write_index = wptr_next[INDEX_W-1:0];
      end
      done_item.done_res = 1'b1;
      done_item.status   = hit_code;
      done_item.last     = 1'b1;

      if (item_valid) begin
         case (item_func)
            FUNC_START: begin
               active_in = 1'b1;
               space_in  = size_eff - SIZE_W'(1);
               wptr_in   = '0;
               len_in    = '0;
               flags_in  = 3'b111;
               reload_in = wait_eff;
               wcount_in = wait_eff;
               push.count = 2'd1;
               push.item_a.write_en    = 1'b1;
               push.item_a.write_index = space_in[INDEX_W-1:0];
               push.item_a.last        = 1'b1;
            end
            FUNC_BYTE: begin
               if (active_ff) begin
                  wcount_in = reload_ff;
                  space_in  = space_next;
                  wptr_in   = wptr_next;
                  if (eol) begin
                     if (hit) begin
                        active_in = 1'b0;
                     end else begin
                        len_in   = '0;
                        flags_in = 3'b111;
                     end
                  end else if (len_ff < LINE_CAP) begin
                     // drop each word that no longer fits the line so far
                     if (len_ff >= L_OK ||
                         word_char(WORD_OK, len_ff[2:0]) != item_rx_byte) begin
                        flags_in[0] = 1'b0;
                     end
                     if (len_ff >= L_ERROR ||
                         word_char(WORD_ERROR, len_ff[2:0]) != item_rx_byte) begin
                        flags_in[1] = 1'b0;
                     end
                     if (len_ff >= L_FAIL ||
                         word_char(WORD_FAIL, len_ff[2:0]) != item_rx_byte) begin
                        flags_in[2] = 1'b0;
                     end
                     len_in = len_ff + LEN_W'(1);
                  end
                  if (store && eol && hit) begin
                     push.count  = 2'd2;
                     push.item_a = store_item;
                     push.item_b = done_item;
                  end else if (store) begin
                     push.count  = 2'd1;
                     push.item_a = store_item;
                  end else if (eol && hit) begin
                     push.count  = 2'd1;
                     push.item_a = done_item;
                  end
               end
            end
            FUNC_TICK: begin
               if (active_ff) begin
                  if (wcount_ff <= WAIT_W'(1)) begin
                     wcount_in = '0;
                     active_in = 1'b0;
                     push.count = 2'd1;
                     push.item_a.done_res = 1'b1;
                     push.item_a.status   = STATUS_TIMEOUT;
                     push.item_a.last     = 1'b1;
                  end else begin
                     wcount_in = wcount_ff - WAIT_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

@@ sv/arlm_rsp_fifo.sv @@
// Result queue of the AT response line matcher: takes up to two results a cycle.
// Depends on arlm_pkg; drains onto the rsp_ channel.
module arlm_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  arlm_pkg::rsp_push_type            push,
   output logic [arlm_pkg::RSP_CNT_W-1:0]    fill,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output arlm_pkg::rsp_item_type            rsp_item
);
   import arlm_pkg::*;

   rsp_item_type            store_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [RSP_CNT_W-1:0]    count_ff, count_in;
   logic [RSP_PTR_W-1:0]    wr_ptr_next;
   logic                    pop;

   assign fill        = count_ff;
   assign rsp_valid   = (count_ff != '0);
   assign rsp_item    = store_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + RSP_PTR_W'(1);

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         store_ff[wr_ptr_ff] <= push.item_a;
      end
      if (push.count == 2'd2) begin
         store_ff[wr_ptr_next] <= push.item_b;
      end
   end

endmodule

@@ sv/at_response_line_matcher.sv @@
// Top level of the AT response line matcher: request register, engine, result queue.
// Depends on arlm_pkg, arlm_engine and arlm_rsp_fifo.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   req     | req_valid, req_stall, func/rx_byte/size/wait  | in
//   rsp     | rsp_valid, rsp_stall, write_*/done/status/last| out
//
// A request is registered on acceptance and processed in the following cycle;
// its results pass the request register and the result queue before they are
// offered. One request a cycle while req_stall is low.
// Each request yields at most two results, queued in an eight-entry queue that
// drains one result a cycle while rsp_stall is low; that drain rate bounds throughput.
// req_stall rises only from queue fill and the request register, never from
// req_valid. Reset is synchronous and clears the command state and the queue.
module at_response_line_matcher #(
   parameter int BUF_MAX  = arlm_pkg::BUF_MAX_DEF,
   parameter int LINE_MAX = arlm_pkg::LINE_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [arlm_pkg::FUNC_W-1:0]   req_func,
   input  logic [arlm_pkg::BYTE_W-1:0]   req_rx_byte,
   input  logic [arlm_pkg::SIZE_W-1:0]   req_buf_size,
   input  logic [arlm_pkg::WAIT_W-1:0]   req_wait_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_write_en,
   output logic [arlm_pkg::INDEX_W-1:0]  rsp_write_index,
   output logic [arlm_pkg::BYTE_W-1:0]   rsp_write_byte,
   output logic                          rsp_done_res,
   output logic [arlm_pkg::STAT_W-1:0]   rsp_status,
   output logic                          rsp_last
);
   import arlm_pkg::*;

   // Request register
   logic                  pend_ff, pend_in;
   logic [FUNC_W-1:0]     func_ff;
   logic [BYTE_W-1:0]     rx_byte_ff;
   logic [SIZE_W-1:0]     buf_size_ff;
   logic [WAIT_W-1:0]     wait_limit_ff;

   logic                  req_take;
   logic [RSP_CNT_W:0]    committed;
   logic [RSP_CNT_W-1:0]  fill;
   rsp_push_type          push;
   rsp_item_type          rsp_item;

   // Hold off a request once the queue fill, counting two results for the
   // request in flight, passes half the queue.
   assign committed = {1'b0, fill} + (pend_ff ? (RSP_CNT_W + 1)'(2) : '0);
   assign req_stall = committed > (RSP_CNT_W + 1)'(RSP_ACCEPT_LIMIT);
   assign req_take  = req_valid && !req_stall;
   assign pend_in   = req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Payload needs no reset: it is only looked at while pend_ff is set
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff       <= req_func;
         rx_byte_ff    <= req_rx_byte;
         buf_size_ff   <= req_buf_size;
         wait_limit_ff <= req_wait_limit;
      end
   end

   arlm_engine #(
      .BUF_MAX  (BUF_MAX),
      .LINE_MAX (LINE_MAX)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (pend_ff),
      .item_func       (func_ff),
      .item_rx_byte    (rx_byte_ff),
      .item_buf_size   (buf_size_ff),
      .item_wait_limit (wait_limit_ff),
      .push            (push)
   );

   arlm_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .fill      (fill),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // Present the head of the queue field by field
   assign rsp_write_en    = rsp_item.write_en;
   assign rsp_write_index = rsp_item.write_index;
   assign rsp_write_byte  = rsp_item.write_byte;
   assign rsp_done_res    = rsp_item.done_res;
   assign rsp_status      = rsp_item.status;
   assign rsp_last        = rsp_item.last;

endmodule
